// ===== hw/rtl/sti_pkg.sv =====
package sti_pkg;

	// Default sizes for the top level
	localparam int COORD_WIDTH_DEF = 32;
	localparam int RATIO_BITS_DEF  = 16;

	// Operand chunk width of the multipliers
	localparam int MUL_CHUNK = 32;

	// Depth of the queue between front and back
	localparam int Q_DEPTH = 2;

	// Width of the configuration register index
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_X = 3'd0,
		REG_START_Y = 3'd1,
		REG_START_Z = 3'd2,
		REG_END_X   = 3'd3,
		REG_END_Y   = 3'd4,
		REG_END_Z   = 3'd5
	} cfg_reg_t;

	// Queue fill status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== hw/rtl/sti_mul.sv =====
// Signed multiplier cut into chunk products; partial products are
// registered, then shifted and summed in the next stage.
module sti_mul #(
	parameter int WA = 33,
	parameter int WB = 33
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [WA-1:0]  a,
	input  logic signed [WB-1:0]  b,
	output logic signed [WA+WB-1:0] p
);
	import sti_pkg::*;

	localparam int C  = MUL_CHUNK;
	localparam int NA = (WA + C - 1) / C;
	localparam int NB = (WB + C - 1) / C;
	localparam int WP = WA + WB;

	logic signed [NA*C-1:0] ax;
	logic signed [NB*C-1:0] bx;
	logic signed [2*C+1:0]  pp_s1 [NA][NB];
	logic signed [WP-1:0]   acc;
	logic signed [WP-1:0]   prod_s2;

	assign ax = (NA*C)'(a);
	assign bx = (NB*C)'(b);

	// top chunk carries the sign, lower chunks are unsigned
	for (genvar i = 0; i < NA; i++) begin : g_a
		for (genvar j = 0; j < NB; j++) begin : g_b
			logic signed [C:0] opa;
			logic signed [C:0] opb;
			assign opa = (i == NA-1) ? {ax[i*C+C-1], ax[i*C +: C]} : {1'b0, ax[i*C +: C]};
			assign opb = (j == NB-1) ? {bx[j*C+C-1], bx[j*C +: C]} : {1'b0, bx[j*C +: C]};
			always_ff @(posedge clk) begin
				if (en) begin
					pp_s1[i][j] <= opa * opb;
				end
			end
		end
	end

	// weighted sum of partial products
	always_comb begin
		acc = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				acc = acc + (WP'(pp_s1[i][j]) <<< ((i + j) * C));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= acc;
		end
	end

	assign p = prod_s2;

endmodule

// ===== hw/rtl/sti_front.sv =====
// Front: edge and offset vectors, coincident vertex check and the four
// cross products (an edge normal against the segment per edge, and the face normal).
// Four stages, all moving on en.
module sti_front #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vin,
	input  logic signed [COORD_WIDTH-1:0] s [3],
	input  logic signed [COORD_WIDTH:0]   d [3],
	input  logic signed [COORD_WIDTH-1:0] vtx [3][3],
	output logic                          vout,
	output logic                          coin,
	output logic signed [COORD_WIDTH:0]   sx [3][3],
	output logic signed [2*COORD_WIDTH+2:0] u [4][3]
);
	localparam int DW = COORD_WIDTH + 1;
	localparam int XW = 2*DW + 1;

	logic [3:0]             vld_q;
	logic                   same;
	logic signed [DW-1:0]   lhs_s1 [4][3];
	logic signed [DW-1:0]   rhs_s1 [4][3];
	logic signed [DW-1:0]   sx_s1 [3][3];
	logic signed [DW-1:0]   sx_s2 [3][3];
	logic signed [DW-1:0]   sx_s3 [3][3];
	logic signed [DW-1:0]   sx_s4 [3][3];
	logic                   coin_s1, coin_s2, coin_s3, coin_s4;
	logic signed [2*DW-1:0] pp [4][3];
	logic signed [2*DW-1:0] pn [4][3];
	logic signed [XW-1:0]   u_s4 [4][3];

	// valid shift line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[2:0], vin};
		end
	end

	// any two vertices with equal codes
	assign same =
		(vtx[0][0] == vtx[1][0] && vtx[0][1] == vtx[1][1] && vtx[0][2] == vtx[1][2]) ||
		(vtx[1][0] == vtx[2][0] && vtx[1][1] == vtx[2][1] && vtx[1][2] == vtx[2][2]) ||
		(vtx[0][0] == vtx[2][0] && vtx[0][1] == vtx[2][1] && vtx[0][2] == vtx[2][2]);

	// stage 1: differences; cross operands are (B-A,C-B,A-C) x D and (B-A) x (C-A)
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				lhs_s1[0][k] <= DW'(vtx[1][k]) - DW'(vtx[0][k]);
				lhs_s1[1][k] <= DW'(vtx[2][k]) - DW'(vtx[1][k]);
				lhs_s1[2][k] <= DW'(vtx[0][k]) - DW'(vtx[2][k]);
				lhs_s1[3][k] <= DW'(vtx[1][k]) - DW'(vtx[0][k]);
				rhs_s1[0][k] <= d[k];
				rhs_s1[1][k] <= d[k];
				rhs_s1[2][k] <= d[k];
				rhs_s1[3][k] <= DW'(vtx[2][k]) - DW'(vtx[0][k]);
				for (int i = 0; i < 3; i++) begin
					sx_s1[i][k] <= DW'(s[k]) - DW'(vtx[i][k]);
				end
			end
			coin_s1 <= same;
		end
	end

	// stages 2-3: component products
	for (genvar x = 0; x < 4; x++) begin : g_x
		for (genvar k = 0; k < 3; k++) begin : g_k
			localparam int K1 = (k + 1) % 3;
			localparam int K2 = (k + 2) % 3;
			sti_mul #(.WA(DW), .WB(DW)) u_mp (
				.clk(clk), .en(en), .a(lhs_s1[x][K1]), .b(rhs_s1[x][K2]), .p(pp[x][k])
			);
			sti_mul #(.WA(DW), .WB(DW)) u_mn (
				.clk(clk), .en(en), .a(lhs_s1[x][K2]), .b(rhs_s1[x][K1]), .p(pn[x][k])
			);
		end
	end

	// stage 4: cross components, side data carried along
	always_ff @(posedge clk) begin
		if (en) begin
			for (int x = 0; x < 4; x++) begin
				for (int k = 0; k < 3; k++) begin
					u_s4[x][k] <= XW'(pp[x][k]) - XW'(pn[x][k]);
				end
			end
			sx_s2   <= sx_s1;
			sx_s3   <= sx_s2;
			sx_s4   <= sx_s3;
			coin_s2 <= coin_s1;
			coin_s3 <= coin_s2;
			coin_s4 <= coin_s3;
		end
	end

	assign vout = vld_q[3];
	assign coin = coin_s4;
	assign sx   = sx_s4;
	assign u    = u_s4;

endmodule

// ===== hw/rtl/sti_queue.sv =====
// Short register queue between front and back.
module sti_queue #(
	parameter int W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              pop,
	input  logic [W-1:0]      din,
	output logic [W-1:0]      dout,
	output sti_pkg::q_stat_t  stat
);
	import sti_pkg::*;

	localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CW = $clog2(Q_DEPTH + 1);

	logic [W-1:0]  mem_q [Q_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign stat.full  = (cnt_q == CW'(Q_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(Q_DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(Q_DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	assign dout = mem_q[rd_q];

endmodule

// ===== hw/rtl/sti_back.sv =====
// Back: triple products, edge tests, sign normalization and a restoring
// divider with one quotient bit per stage. RATIO_BITS+6 stages on en.
module sti_back #(
	parameter int COORD_WIDTH = 32,
	parameter int RATIO_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            vin,
	input  logic                            coin,
	input  logic signed [COORD_WIDTH:0]     sx [3][3],
	input  logic signed [2*COORD_WIDTH+2:0] u [4][3],
	input  logic signed [COORD_WIDTH:0]     d [3],
	output logic                            vout,
	output logic                            hit,
	output logic [RATIO_BITS:0]             ratio
);
	localparam int DW  = COORD_WIDTH + 1;
	localparam int XW  = 2*DW + 1;
	localparam int PW  = DW + XW;
	localparam int SW  = PW + 2;
	localparam int NBS = RATIO_BITS + 6;
	localparam int QW  = RATIO_BITS + 1;

	logic [NBS-1:0]          vld_q;
	logic signed [DW-1:0]    dot_a [5][3];
	logic signed [XW-1:0]    dot_b [5][3];
	logic signed [PW-1:0]    prod [5][3];
	logic                    coin_s1, coin_s2, coin_s3;
	logic signed [SW-1:0]    dot_s3 [5];
	logic signed [SW-1:0]    den, dd;
	logic [2:0]              pass;
	logic                    ok_s4;
	logic signed [SW-1:0]    num_s4, dn_s4;
	logic                    ok5, q0;
	// divider: index g holds stage 5+g
	logic [SW-1:0]           rem_s5 [RATIO_BITS+1];
	logic [SW-1:0]           dn_s5 [RATIO_BITS+1];
	logic [QW-1:0]           q_s5 [RATIO_BITS+1];
	logic                    ok_s5 [RATIO_BITS+1];
	logic                    hit_q;
	logic [QW-1:0]           ratio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NBS-2:0], vin};
		end
	end

	// operand routing: an edge product per edge, face term, denominator
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				dot_a[j][k] = sx[j][k];
				dot_b[j][k] = u[j][k];
			end
			dot_a[3][k] = sx[0][k];
			dot_b[3][k] = u[3][k];
			dot_a[4][k] = d[k];
			dot_b[4][k] = u[3][k];
		end
	end

	// stages 1-2: products
	for (genvar j = 0; j < 5; j++) begin : g_dot
		for (genvar k = 0; k < 3; k++) begin : g_k
			sti_mul #(.WA(DW), .WB(XW)) u_m (
				.clk(clk), .en(en), .a(dot_a[j][k]), .b(dot_b[j][k]), .p(prod[j][k])
			);
		end
	end

	// stage 3: dot sums
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 5; j++) begin
				dot_s3[j] <= SW'(prod[j][0]) + SW'(prod[j][1]) + SW'(prod[j][2]);
			end
			coin_s1 <= coin;
			coin_s2 <= coin_s1;
			coin_s3 <= coin_s2;
		end
	end

	// stage 4: edge tests; every edge shares dd = -(D.N)
	assign den = dot_s3[4];
	assign dd  = -den;
	always_comb begin
		for (int e = 0; e < 3; e++) begin
			if (!dd[SW-1]) begin
				pass[e] = !dot_s3[e][SW-1] && (dot_s3[e] <= dd);
			end else begin
				pass[e] = (dot_s3[e][SW-1] || dot_s3[e] == '0) && (dot_s3[e] >= dd);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s4  <= !coin_s3 && (&pass) && (den != '0);
			num_s4 <= den[SW-1] ? dot_s3[3] : -dot_s3[3];
			dn_s4  <= den[SW-1] ? -den : den;
		end
	end

	// stage 5: range check and leading quotient bit
	assign ok5 = ok_s4 && !num_s4[SW-1] && (num_s4 <= dn_s4);
	assign q0  = (num_s4 == dn_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s5[0]  <= ok5;
			rem_s5[0] <= q0 ? '0 : num_s4;
			dn_s5[0]  <= dn_s4;
			q_s5[0]   <= QW'(q0);
		end
	end

	// restoring division, one bit per stage
	for (genvar g = 1; g <= RATIO_BITS; g++) begin : g_div
		logic [SW-1:0] r2;
		logic          ge;
		assign r2 = {rem_s5[g-1][SW-2:0], 1'b0};
		assign ge = (r2 >= dn_s5[g-1]);
		always_ff @(posedge clk) begin
			if (en) begin
				ok_s5[g]  <= ok_s5[g-1];
				rem_s5[g] <= ge ? r2 - dn_s5[g-1] : r2;
				dn_s5[g]  <= dn_s5[g-1];
				q_s5[g]   <= {q_s5[g-1][QW-2:0], ge};
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			hit_q   <= ok_s5[RATIO_BITS];
			ratio_q <= ok_s5[RATIO_BITS] ? q_s5[RATIO_BITS] : '0;
		end
	end

	assign vout  = vld_q[NBS-1];
	assign hit   = hit_q;
	assign ratio = ratio_q;

endmodule

// ===== hw/rtl/segment_triangle_intersect.sv =====
// Segment versus triangle test, one triangle per cycle when not stalled.
// The path from input transfer to result runs through 4 front stages, the
// queue, 5 product/test stages, one divider stage per ratio bit and the
// output register.
// Reset clears segment registers to zero and empties pipeline and queue.
module segment_triangle_intersect #(
	parameter int COORD_WIDTH = sti_pkg::COORD_WIDTH_DEF,
	parameter int RATIO_BITS  = sti_pkg::RATIO_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sti_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic signed [COORD_WIDTH-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [COORD_WIDTH-1:0]  vertex_a_x,
	input  logic signed [COORD_WIDTH-1:0]  vertex_a_y,
	input  logic signed [COORD_WIDTH-1:0]  vertex_a_z,
	input  logic signed [COORD_WIDTH-1:0]  vertex_b_x,
	input  logic signed [COORD_WIDTH-1:0]  vertex_b_y,
	input  logic signed [COORD_WIDTH-1:0]  vertex_b_z,
	input  logic signed [COORD_WIDTH-1:0]  vertex_c_x,
	input  logic signed [COORD_WIDTH-1:0]  vertex_c_y,
	input  logic signed [COORD_WIDTH-1:0]  vertex_c_z,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           hit,
	output logic [RATIO_BITS:0]            ratio
);
	import sti_pkg::*;

	localparam int DW = COORD_WIDTH + 1;
	localparam int XW = 2*DW + 1;
	localparam int QW = 1 + 9*DW + 12*XW;

	logic signed [COORD_WIDTH-1:0] start_q [3];
	logic signed [COORD_WIDTH-1:0] end_q [3];
	logic signed [DW-1:0]          d [3];
	logic signed [COORD_WIDTH-1:0] vtx [3][3];
	logic                          en_f, en_b, f_vld, f_coin, push, pop;
	logic signed [DW-1:0]          f_sx [3][3];
	logic signed [XW-1:0]          f_u [4][3];
	logic [QW-1:0]                 q_in, q_out;
	q_stat_t                       qs;
	logic signed [DW-1:0]          b_sx [3][3];
	logic signed [XW-1:0]          b_u [4][3];

	// segment registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '{default: '0};
			end_q   <= '{default: '0};
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_START_X: start_q[0] <= cfg_data;
				REG_START_Y: start_q[1] <= cfg_data;
				REG_START_Z: start_q[2] <= cfg_data;
				REG_END_X:   end_q[0]   <= cfg_data;
				REG_END_Y:   end_q[1]   <= cfg_data;
				REG_END_Z:   end_q[2]   <= cfg_data;
				default: ;
			endcase
		end
	end

	// segment direction
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d[k] = DW'(end_q[k]) - DW'(start_q[k]);
		end
	end

	assign vtx[0] = '{vertex_a_x, vertex_a_y, vertex_a_z};
	assign vtx[1] = '{vertex_b_x, vertex_b_y, vertex_b_z};
	assign vtx[2] = '{vertex_c_x, vertex_c_y, vertex_c_z};

	// flow control: front waits only on a full queue, back only on the output
	assign en_f     = !f_vld || !qs.full;
	assign in_stall = !en_f;
	assign push     = f_vld && en_f;
	assign en_b     = !out_valid || !out_stall;
	assign pop      = en_b && !qs.empty;

	sti_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en_f), .vin(in_valid),
		.s(start_q), .d(d), .vtx(vtx),
		.vout(f_vld), .coin(f_coin), .sx(f_sx), .u(f_u)
	);

	// pack and unpack queue entries
	always_comb begin
		q_in[0] = f_coin;
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				q_in[1 + (i*3 + k)*DW +: DW] = f_sx[i][k];
			end
		end
		for (int x = 0; x < 4; x++) begin
			for (int k = 0; k < 3; k++) begin
				q_in[1 + 9*DW + (x*3 + k)*XW +: XW] = f_u[x][k];
			end
		end
	end

	sti_queue #(.W(QW)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .pop(pop),
		.din(q_in), .dout(q_out), .stat(qs)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				b_sx[i][k] = q_out[1 + (i*3 + k)*DW +: DW];
			end
		end
		for (int x = 0; x < 4; x++) begin
			for (int k = 0; k < 3; k++) begin
				b_u[x][k] = q_out[1 + 9*DW + (x*3 + k)*XW +: XW];
			end
		end
	end

	sti_back #(.COORD_WIDTH(COORD_WIDTH), .RATIO_BITS(RATIO_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .en(en_b), .vin(!qs.empty),
		.coin(q_out[0]), .sx(b_sx), .u(b_u), .d(d),
		.vout(out_valid), .hit(hit), .ratio(ratio)
	);

endmodule

// ===== hw/rtl/sti_check.sv =====
// Port-level checks on the result channel.
module sti_check #(
	parameter int RATIO_BITS = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic                  hit,
	input logic [RATIO_BITS:0]   ratio
);
	localparam logic [RATIO_BITS:0] RATIO_ONE = (RATIO_BITS+1)'(1) << RATIO_BITS;

	// stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// stalled result does not change
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(hit) && $stable(ratio))
		else $error("result changed while stalled");

	// miss carries a zero position
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> ratio == '0)
		else $error("nonzero ratio on miss");

	// hit lies within the segment
	a_hit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> ratio <= RATIO_ONE)
		else $error("ratio beyond segment end");

endmodule

bind segment_triangle_intersect sti_check #(.RATIO_BITS(RATIO_BITS)) u_check (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.hit(hit), .ratio(ratio)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import sti_pkg::*;

	localparam int CW = 32;
	localparam int RB = 16;
	localparam int ONE = 65536;
	localparam logic signed [CW-1:0] CMIN = 32'sh8000_0000;
	localparam logic signed [CW-1:0] CMAX = 32'sh7fff_ffff;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [191:0] wide_t;
	typedef struct packed {
		wide_t x;
		wide_t y;
		wide_t z;
	} wvec_t;
	// vertex coordinates a.xyz, b.xyz, c.xyz
	typedef struct {
		coord_t v[9];
	} tri_t;
	typedef struct {
		logic hit;
		logic [RB:0] ratio;
	} isect_t;
	typedef struct {
		tri_t t;
		bit known;
		isect_t want;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_START_X;
	logic signed [CW-1:0] cfg_data = 0;
	logic in_valid = 0;
	logic in_stall;
	coord_t vertex_a_x = 0, vertex_a_y = 0, vertex_a_z = 0;
	coord_t vertex_b_x = 0, vertex_b_y = 0, vertex_b_z = 0;
	coord_t vertex_c_x = 0, vertex_c_y = 0, vertex_c_z = 0;
	logic out_valid;
	logic out_stall = 0;
	logic hit;
	logic [RB:0] ratio;

	// segment copy held by the bench
	coord_t seg_start[3];
	coord_t seg_end[3];
	isect_t pending_q[$];
	isect_t known_q[$];
	bit known_flag_q[$];
	int err_count = 0;

	segment_triangle_intersect dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.vertex_a_x(vertex_a_x), .vertex_a_y(vertex_a_y), .vertex_a_z(vertex_a_z),
		.vertex_b_x(vertex_b_x), .vertex_b_y(vertex_b_y), .vertex_b_z(vertex_b_z),
		.vertex_c_x(vertex_c_x), .vertex_c_y(vertex_c_y), .vertex_c_z(vertex_c_z),
		.out_valid(out_valid), .out_stall(out_stall), .hit(hit), .ratio(ratio)
	);

	always #5 clk = ~clk;

	// exact vector math at full width
	function automatic wvec_t wv(coord_t x, coord_t y, coord_t z);
		wvec_t r;
		r.x = wide_t'(x);
		r.y = wide_t'(y);
		r.z = wide_t'(z);
		return r;
	endfunction

	function automatic wvec_t vdiff(wvec_t a, wvec_t b);
		wvec_t r;
		r.x = a.x - b.x;
		r.y = a.y - b.y;
		r.z = a.z - b.z;
		return r;
	endfunction

	function automatic wvec_t vcross(wvec_t a, wvec_t b);
		wvec_t r;
		r.x = a.y * b.z - a.z * b.y;
		r.y = a.z * b.x - a.x * b.z;
		r.z = a.x * b.y - a.y * b.x;
		return r;
	endfunction

	function automatic wide_t vdot(wvec_t a, wvec_t b);
		return a.x * b.x + a.y * b.y + a.z * b.z;
	endfunction

	// one edge: segment start must lie between the edge plane and the opposite vertex
	function automatic bit edge_pass(wvec_t p, wvec_t q, wvec_t o, wvec_t s, wvec_t d,
			inout bit zero);
		wvec_t n;
		wide_t ds, dd;
		n = vcross(vdiff(q, p), d);
		ds = vdot(vdiff(s, p), n);
		dd = vdot(vdiff(o, p), n);
		if (dd == 0) zero = 1;
		if (dd >= 0) return ds >= 0 && dd >= ds;
		return ds <= 0 && ds >= dd;
	endfunction

	function automatic isect_t predict_crossing(tri_t t);
		isect_t r;
		wvec_t a, b, c, s, d, n;
		wide_t num, den, quo;
		bit zero;
		r.hit = 0;
		r.ratio = 0;
		zero = 0;
		a = wv(t.v[0], t.v[1], t.v[2]);
		b = wv(t.v[3], t.v[4], t.v[5]);
		c = wv(t.v[6], t.v[7], t.v[8]);
		if (a == b || b == c || a == c) return r;
		s = wv(seg_start[0], seg_start[1], seg_start[2]);
		d = vdiff(wv(seg_end[0], seg_end[1], seg_end[2]), s);
		if (!edge_pass(a, b, c, s, d, zero)) return r;
		if (!edge_pass(b, c, a, s, d, zero)) return r;
		if (!edge_pass(c, a, b, s, d, zero)) return r;
		if (zero) return r;
		n = vcross(vdiff(b, a), vdiff(c, a));
		num = vdot(vdiff(a, s), n);
		den = vdot(d, n);
		if (den == 0) return r;
		if (den < 0) begin
			den = -den;
			num = -num;
		end
		if (num < 0 || num > den) return r;
		quo = (num <<< RB) / den;
		r.hit = 1;
		r.ratio = quo[RB:0];
		return r;
	endfunction

	// record every input transfer with its prediction
	always @(posedge clk) begin
		tri_t t;
		if (in_valid && !in_stall) begin
			t.v = '{vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
				vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z};
			pending_q.push_back(predict_crossing(t));
		end
	end

	// check every output transfer against the typed row or the oldest prediction
	always @(posedge clk) begin
		isect_t w;
		bit use_known;
		if (out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				$error("result with no transfer waiting: hit=%0d ratio=%0d", hit, ratio);
				err_count++;
			end else begin
				w = pending_q.pop_front();
				use_known = 0;
				if (known_flag_q.size() > 0) begin
					use_known = known_flag_q.pop_front();
				end
				if (use_known && known_q.size() > 0) begin
					w = known_q.pop_front();
				end
				if (hit !== w.hit) begin
					$error("hit: expected %0d actual %0d", w.hit, hit);
					err_count++;
				end
				if (ratio !== w.ratio) begin
					$error("ratio: expected %0d actual %0d", w.ratio, ratio);
					err_count++;
				end
			end
		end
	end

	// receiver stall pattern: modes of random length
	int stall_mode = 0;
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(5, 60);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0, 1: out_stall <= 0;
			2: out_stall <= ($urandom_range(0, 1) == 1);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	task automatic write_reg(cfg_reg_t idx, coord_t val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx <= REG_START_Z) seg_start[idx] = val;
		else seg_end[idx - REG_END_X] = val;
	endtask

	task automatic set_segment(coord_t sx, coord_t sy, coord_t sz, coord_t ex, coord_t ey,
			coord_t ez);
		// stop sending and let the pipeline drain before the segment changes
		in_valid <= 0;
		wait (pending_q.size() == 0);
		repeat (30) @(posedge clk);
		write_reg(REG_START_X, sx);
		write_reg(REG_START_Y, sy);
		write_reg(REG_START_Z, sz);
		write_reg(REG_END_X, ex);
		write_reg(REG_END_Y, ey);
		write_reg(REG_END_Z, ez);
	endtask

	// sender: one transfer, with a possible gap before it when the burst runs out
	int burst_left = 0;
	task automatic send_tri(tri_t t);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1;
		{vertex_a_x, vertex_a_y, vertex_a_z} <= {t.v[0], t.v[1], t.v[2]};
		{vertex_b_x, vertex_b_y, vertex_b_z} <= {t.v[3], t.v[4], t.v[5]};
		{vertex_c_x, vertex_c_y, vertex_c_z} <= {t.v[6], t.v[7], t.v[8]};
		do @(posedge clk); while (in_stall);
	endtask

	function automatic coord_t pick_edge_value();
		case ($urandom_range(0, 4))
			0: return CMIN;
			1: return CMAX;
			2: return 0;
			3: return -1;
			default: return $urandom;
		endcase
	endfunction

	// random triangle: mostly placed around the segment midpoint
	function automatic tri_t random_tri();
		tri_t t;
		longint mid, span, reach;
		int kind;
		kind = $urandom_range(0, 19);
		for (int i = 0; i < 9; i++) begin
			if (kind < 13) begin
				mid = (longint'(seg_start[i % 3]) + longint'(seg_end[i % 3])) / 2;
				span = longint'(seg_end[i % 3]) - longint'(seg_start[i % 3]);
				if (span < 0) span = -span;
				reach = span + 64 + $urandom_range(0, 65536);
				t.v[i] = coord_t'(mid + ($urandom % (2 * reach + 1)) - reach);
			end else if (kind < 17) begin
				t.v[i] = $urandom;
			end else begin
				t.v[i] = pick_edge_value();
			end
		end
		// occasionally make two vertices coincide
		if ($urandom_range(0, 12) == 0) begin
			case ($urandom_range(0, 2))
				0: for (int i = 0; i < 3; i++) t.v[3 + i] = t.v[i];
				1: for (int i = 0; i < 3; i++) t.v[6 + i] = t.v[3 + i];
				default: for (int i = 0; i < 3; i++) t.v[6 + i] = t.v[i];
			endcase
		end
		return t;
	endfunction

	function automatic row_t mk_row(coord_t ax, coord_t ay, coord_t az, coord_t bx, coord_t by,
			coord_t bz, coord_t cx, coord_t cy, coord_t cz, bit known, bit h, int r);
		row_t row;
		row.t.v = '{ax, ay, az, bx, by, bz, cx, cy, cz};
		row.known = known;
		row.want.hit = h;
		row.want.ratio = (RB+1)'(r);
		return row;
	endfunction

	task automatic run_random(int count);
		for (int k = 0; k < count; k++) begin
			known_flag_q.push_back(0);
			send_tri(random_tri());
		end
	endtask

	initial begin
		row_t table_rows[$];
		coord_t u;

		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// zero-length segment after reset: every triangle misses
		known_flag_q.push_back(1);
		known_q.push_back('{0, 0});
		send_tri(mk_row(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0, 0, 0, 0).t);
		run_random(40);

		// segment along z from -1.0 to 1.0
		set_segment(0, 0, -ONE, 0, 0, ONE);
		u = ONE;
		// plane crossings at middle, end, start and three quarters
		table_rows.push_back(mk_row(-u, -u, 0, u, -u, 0, 0, u, 0, 1, 1, ONE / 2));
		table_rows.push_back(mk_row(-u, -u, u, u, -u, u, 0, u, u, 1, 1, ONE));
		table_rows.push_back(mk_row(-u, -u, -u, u, -u, -u, 0, u, -u, 1, 1, 0));
		table_rows.push_back(mk_row(0, u, u/2, u, -u, u/2, -u, -u, u/2, 1, 1, 3 * ONE / 4));
		// beyond either end of the segment
		table_rows.push_back(mk_row(-u, -u, 2*u, u, -u, 2*u, 0, u, 2*u, 1, 0, 0));
		table_rows.push_back(mk_row(-u, -u, -2*u, u, -u, -2*u, 0, u, -2*u, 1, 0, 0));
		// off to the side
		table_rows.push_back(mk_row(2*u, 2*u, 0, 3*u, 2*u, 0, 2*u, 3*u, 0, 1, 0, 0));
		// coincident vertices, each pair
		table_rows.push_back(mk_row(-u, -u, 0, -u, -u, 0, 0, u, 0, 1, 0, 0));
		table_rows.push_back(mk_row(-u, -u, 0, u, -u, 0, u, -u, 0, 1, 0, 0));
		table_rows.push_back(mk_row(0, u, 0, u, -u, 0, 0, u, 0, 1, 0, 0));
		// parallel to the segment, and a collinear triangle
		table_rows.push_back(mk_row(0, -u, -u, 0, u, -u, 0, 0, u, 1, 0, 0));
		table_rows.push_back(mk_row(-u, 0, 0, 0, 0, 0, u, 0, 0, 1, 0, 0));
		// crossing on an edge and on a vertex
		table_rows.push_back(mk_row(0, -u, 0, 0, u, 0, u, 0, 0, 0, 0, 0));
		table_rows.push_back(mk_row(0, 0, 0, u, 0, 0, 0, u, 0, 0, 0, 0));
		// extremes of the coordinate range
		table_rows.push_back(mk_row(CMIN, CMIN, 0, CMAX, CMIN, 0, 0, CMAX, 0, 0, 0, 0));
		table_rows.push_back(mk_row(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, 0,
			0, 0, 0));
		table_rows.push_back(mk_row(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, -1, -1, -1, 0, 0, 0));
		table_rows.push_back(mk_row(-1, 0, -1, 0, -1, 0, CMAX, CMAX, CMIN, 0, 0, 0));
		foreach (table_rows[i]) begin
			known_flag_q.push_back(table_rows[i].known);
			if (table_rows[i].known) known_q.push_back(table_rows[i].want);
			send_tri(table_rows[i].t);
		end
		run_random(150);

		// full-range diagonal segment
		set_segment(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
		run_random(150);
		// reversed extremes
		set_segment(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN);
		run_random(150);

		// random short and long segments
		for (int p = 0; p < 4; p++) begin
			if (p[0])
				set_segment($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			else
				set_segment($signed($urandom_range(0, 1 << 22)) - (1 << 21),
					$signed($urandom_range(0, 1 << 22)) - (1 << 21),
					$signed($urandom_range(0, 1 << 22)) - (1 << 21),
					$signed($urandom_range(0, 1 << 22)) - (1 << 21),
					$signed($urandom_range(0, 1 << 22)) - (1 << 21),
					$signed($urandom_range(0, 1 << 22)) - (1 << 21));
			run_random(130);
		end

		in_valid <= 0;
		wait (pending_q.size() == 0);
		repeat (40) @(posedge clk);
		if (err_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// run limit
	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
